>>> hw/rtl/plsp_pkg.sv
// Package: sizes, register indexes and shared types of the per-slot load predictor.
package plsp_pkg;

  localparam int unsigned SlotCountMax = 64;
  localparam int unsigned SampleBits   = 16;
  localparam int unsigned SlotIdxBits  = $clog2(SlotCountMax);
  localparam int unsigned SlotCntBits  = 7;
  localparam int unsigned FactorBits   = 17;
  localparam int unsigned CfgIdxBits   = 2;
  localparam int unsigned CfgDataBits  = 17;

  localparam logic [FactorBits-1:0] FactorOne  = FactorBits'(65536);
  localparam logic [FactorBits-1:0] FactorHalf = FactorBits'(32768);

  localparam logic [SlotCntBits-1:0] SlotsResetVal = SlotCntBits'(64);
  localparam logic [SlotCntBits-1:0] SlotsMaxVal   = SlotCntBits'(SlotCountMax);

  // register indexes of the configuration port
  typedef enum logic [CfgIdxBits-1:0] {
    CFG_SLOTS_IN_USE     = 2'd0,
    CFG_SMOOTHING_FACTOR = 2'd1
  } cfg_idx_e;

  // operation of one input word
  typedef enum logic {
    FUNC_LOAD  = 1'b0,
    FUNC_BLEND = 1'b1
  } func_e;

  // item held in the blend stage while the slot memory is read
  typedef struct packed {
    func_e                  func;
    logic [SampleBits-1:0]  sample;
    logic [SlotIdxBits-1:0] idx;
    logic                   last;
  } stage_t;

endpackage

>>> hw/rtl/plsp_slot_ram.sv
// Slot store: single-port-write, registered-read memory of smoothed loads.
module plsp_slot_ram (
  input  logic                            clk_i,
  input  logic                            re_i,
  input  logic [plsp_pkg::SlotIdxBits-1:0] raddr_i,
  output logic [plsp_pkg::SampleBits-1:0]  rdata_o,
  input  logic                            we_i,
  input  logic [plsp_pkg::SlotIdxBits-1:0] waddr_i,
  input  logic [plsp_pkg::SampleBits-1:0]  wdata_i
);
  import plsp_pkg::*;

  logic [SampleBits-1:0] mem_q [SlotCountMax];
  logic [SampleBits-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read port, read-before-write on a clash
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/plsp_blend.sv
// Blend unit: old + round((sample - old) * f / 2^16), or plain load.
module plsp_blend (
  input  plsp_pkg::func_e                 func_i,
  input  logic [plsp_pkg::SampleBits-1:0] old_i,
  input  logic [plsp_pkg::SampleBits-1:0] sample_i,
  input  logic [plsp_pkg::FactorBits-1:0] factor_i,
  output logic [plsp_pkg::SampleBits-1:0] result_o
);
  import plsp_pkg::*;

  localparam int unsigned DiffBits = SampleBits + 1;
  localparam int unsigned ProdBits = DiffBits + FactorBits + 1;

  logic signed [DiffBits-1:0] diff;
  logic signed [ProdBits-1:0] prod;
  logic signed [ProdBits-1:0] rounded;
  logic signed [ProdBits-1:0] step;
  logic        [ProdBits-1:0] sum;

  // old*(1-f) + s*f == old*2^16 + (s-old)*f, so one signed product suffices
  always_comb begin
    diff    = $signed({1'b0, sample_i}) - $signed({1'b0, old_i});
    prod    = ProdBits'(diff) * $signed({1'b0, factor_i});
    rounded = prod + $signed(ProdBits'({1'b0, FactorHalf}));
    step    = rounded >>> 16;
    sum     = ProdBits'(old_i) + $unsigned(step);
    if (func_i == FUNC_LOAD) begin
      result_o = sample_i;
    end else begin
      result_o = sum[SampleBits-1:0];
    end
  end

endmodule

>>> hw/rtl/per_slot_ewma_load_predictor.sv
// Top level: per-slot smoothed load predictor with slot counter and pipeline.
//
//   port group | direction | handshake              | contents
//   -----------+-----------+------------------------+-----------------------------
//   in         | in        | in_valid_i / in_stall_o | func_i, sample_i
//   out        | out       | out_valid_o/out_stall_i | prediction, slot_index, end
//   cfg        | in        | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// One word per cycle while in_stall_o is low; a taken input word goes into the blend
// stage register, and its result is then loaded into the output register.
// Stage 0 reads the slot memory, stage 1 blends and writes back; a result
// for the same slot written back as the slot is read is forwarded past the memory.
// Reset clears the slot counter and loads the registers; the store is not cleared.
// A stall on the output holds the blend stage and then stalls the input.
module per_slot_ewma_load_predictor (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic                               func_i,
  input  logic [plsp_pkg::SampleBits-1:0]    sample_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [plsp_pkg::SampleBits-1:0]    prediction_o,
  output logic [plsp_pkg::SlotIdxBits-1:0]   slot_index_o,
  output logic                               cycle_end_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [plsp_pkg::CfgIdxBits-1:0]    cfg_index_i,
  input  logic [plsp_pkg::CfgDataBits-1:0]   cfg_data_i
);
  import plsp_pkg::*;

  logic [SlotCntBits-1:0] slots_q;
  logic [FactorBits-1:0]  factor_q;
  logic [SlotIdxBits-1:0] cnt_q, cnt_d;
  logic                   s1_valid_q;
  stage_t                 s1_q, s0;
  logic                   fwd_hit_q;
  logic [SampleBits-1:0]  fwd_data_q;
  logic                   out_valid_q;
  logic [SampleBits-1:0]  out_pred_q;
  logic [SlotIdxBits-1:0] out_idx_q;
  logic                   out_end_q;

  logic [SlotCntBits-1:0] slots_eff;
  logic [FactorBits-1:0]  factor_eff;
  logic                   in_acc;
  logic                   s1_adv;
  logic                   fwd_hit;
  logic [SampleBits-1:0]  rdata;
  logic [SampleBits-1:0]  old_val;
  logic [SampleBits-1:0]  wdata;

  // configuration registers, always ready
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slots_q  <= SlotsResetVal;
      factor_q <= FactorHalf;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_SLOTS_IN_USE:     slots_q  <= cfg_data_i[SlotCntBits-1:0];
        CFG_SMOOTHING_FACTOR: factor_q <= cfg_data_i[FactorBits-1:0];
        default: ;
      endcase
    end
  end

  // clamp slot count to 1..max and the weight to 1.0
  always_comb begin
    slots_eff = slots_q;
    if (slots_q == '0) begin
      slots_eff = SlotCntBits'(1);
    end else if (slots_q > SlotsMaxVal) begin
      slots_eff = SlotsMaxVal;
    end
    factor_eff = (factor_q > FactorOne) ? FactorOne : factor_q;
  end

  // pipeline flow
  assign s1_adv     = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign in_acc     = in_valid_i && !in_stall_o;

  // stage 0: slot selection and end-of-cycle mark
  always_comb begin
    s0.func   = func_e'(func_i);
    s0.sample = sample_i;
    s0.idx    = cnt_q;
    s0.last   = ({1'b0, cnt_q} + SlotCntBits'(1)) >= slots_eff;
    cnt_d     = s0.last ? '0 : cnt_q + SlotIdxBits'(1);
  end

  // forward when the word ahead writes the slot being read
  assign fwd_hit = s1_adv && (s1_q.idx == cnt_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q      <= '0;
      s1_valid_q <= 1'b0;
      fwd_hit_q  <= 1'b0;
    end else begin
      if (in_acc) begin
        cnt_q <= cnt_d;
      end
      if (in_acc) begin
        s1_valid_q <= 1'b1;
        fwd_hit_q  <= fwd_hit;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
        fwd_hit_q  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_q       <= s0;
      fwd_data_q <= wdata;
    end
  end

  plsp_slot_ram u_ram (
    .clk_i   (clk_i),
    .re_i    (in_acc),
    .raddr_i (cnt_q),
    .rdata_o (rdata),
    .we_i    (s1_adv),
    .waddr_i (s1_q.idx),
    .wdata_i (wdata)
  );

  // stage 1: blend and write back
  assign old_val = fwd_hit_q ? fwd_data_q : rdata;

  plsp_blend u_blend (
    .func_i   (s1_q.func),
    .old_i    (old_val),
    .sample_i (s1_q.sample),
    .factor_i (factor_eff),
    .result_o (wdata)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_pred_q <= wdata;
      out_idx_q  <= s1_q.idx;
      out_end_q  <= s1_q.last;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign prediction_o = out_pred_q;
  assign slot_index_o = out_idx_q;
  assign cycle_end_o  = out_end_q;

  // checks
  a_stall_needs_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s1_valid_q && out_valid_q && out_stall_i))
    else $error("input stalled with a free blend stage");

  a_wrap_to_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && s0.last) |=> (cnt_q == '0))
    else $error("slot counter did not wrap after the last slot");

  a_load_stores_sample: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && s1_q.func == FUNC_LOAD) |-> (wdata == s1_q.sample))
    else $error("load word does not store its sample");

  a_fwd_only_with_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fwd_hit_q |-> s1_valid_q)
    else $error("forwarding without a word in the blend stage");

endmodule

>>> test/tb_top.sv
// Testbench for the per-slot smoothed load predictor: stimulus, predictor and result checker.
`timescale 1ns / 1ps

module tb_top;
  import plsp_pkg::*;

  // one input word as the driver sends it
  typedef struct packed {
    func_e                 op;
    logic [SampleBits-1:0] sample;
  } load_word_t;

  // one pending register write
  typedef struct packed {
    cfg_idx_e               idx;
    logic [CfgDataBits-1:0] data;
  } reg_write_t;

  // one result word
  typedef struct packed {
    logic [SampleBits-1:0]  prediction;
    logic [SlotIdxBits-1:0] slot;
    logic                   last;
  } slot_result_t;

  logic                   clk_i       = 1'b0;
  logic                   rst_ni      = 1'b0;
  logic                   in_valid_i  = 1'b0;
  logic                   in_stall_o;
  func_e                  func_i      = FUNC_LOAD;
  logic [SampleBits-1:0]  sample_i    = '0;
  logic                   out_valid_o;
  logic                   out_stall_i = 1'b0;
  logic [SampleBits-1:0]  prediction_o;
  logic [SlotIdxBits-1:0] slot_index_o;
  logic                   cycle_end_o;
  logic                   cfg_valid_i = 1'b0;
  logic                   cfg_ready_o;
  logic [CfgIdxBits-1:0]  cfg_index_i = '0;
  logic [CfgDataBits-1:0] cfg_data_i  = '0;

  per_slot_ewma_load_predictor DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .func_i       (func_i),
    .sample_i     (sample_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .prediction_o (prediction_o),
    .slot_index_o (slot_index_o),
    .cycle_end_o  (cycle_end_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // stimulus queues and bookkeeping
  load_word_t   word_q[$];
  reg_write_t   reg_q[$];
  slot_result_t awaited_q[$];
  int unsigned  issued     = 0;
  int unsigned  accepted   = 0;
  int unsigned  cfg_posted = 0;
  int unsigned  cfg_done   = 0;
  int unsigned  faults     = 0;
  bit           bursts_on  = 1'b1;

  // predictor state, mirrors the block
  logic [SampleBits-1:0]  slot_val [SlotCountMax];
  logic [SlotIdxBits-1:0] slot_ctr   = '0;
  logic [SlotCntBits-1:0] slots_cfg  = SlotsResetVal;
  logic [FactorBits-1:0]  factor_cfg = FactorHalf;

  // planning state: keeps blends off slots that were never loaded
  bit          plan_seen [SlotCountMax];
  int unsigned plan_ctr   = 0;
  int unsigned plan_slots = SlotCountMax;

  function automatic int unsigned eff_slots(input logic [SlotCntBits-1:0] raw);
    int unsigned n;
    n = raw;
    if (n == 0) n = 1;
    if (n > SlotCountMax) n = SlotCountMax;
    return n;
  endfunction

  // works out the result of one accepted word and updates the slot
  function automatic void advance_slot(input func_e op, input logic [SampleBits-1:0] smp);
    int unsigned           n;
    logic [SlotIdxBits-1:0] idx;
    logic [FactorBits-1:0]  f;
    logic [47:0]            acc;
    slot_result_t           r;
    n   = eff_slots(slots_cfg);
    idx = slot_ctr;
    f   = (factor_cfg > FactorOne) ? FactorOne : factor_cfg;
    if (op == FUNC_LOAD) begin
      r.prediction = smp;
    end else begin
      acc = 48'(slot_val[idx]) * 48'(FactorOne - f) + 48'(smp) * 48'(f) + 48'(FactorHalf);
      r.prediction = acc[16 +: SampleBits];
    end
    r.slot = idx;
    r.last = ((idx + 1) >= n);
    slot_val[idx] = r.prediction;
    slot_ctr = r.last ? '0 : idx + 1'b1;
    awaited_q.push_back(r);
  endfunction

  function automatic void note_fault(input string msg);
    if (faults < 10) $display("%0t: %s", $time, msg);
    faults++;
  endfunction

  // queue a word; a blend on a slot never loaded becomes a load
  function automatic void queue_word(input func_e op, input logic [SampleBits-1:0] smp);
    func_e      op_eff;
    load_word_t w;
    op_eff = op;
    if (op == FUNC_BLEND && !plan_seen[plan_ctr]) op_eff = FUNC_LOAD;
    plan_seen[plan_ctr] = 1'b1;
    plan_ctr = (plan_ctr + 1 >= plan_slots) ? 0 : plan_ctr + 1;
    w.op     = op_eff;
    w.sample = smp;
    word_q.push_back(w);
    issued++;
  endfunction

  function automatic void post_reg(input cfg_idx_e idx, input logic [CfgDataBits-1:0] data);
    reg_write_t rw;
    rw.idx  = idx;
    rw.data = data;
    reg_q.push_back(rw);
    cfg_posted++;
    if (idx == CFG_SLOTS_IN_USE) plan_slots = eff_slots(data[SlotCntBits-1:0]);
  endfunction

  function automatic logic [SampleBits-1:0] pick_sample();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return SampleBits'($urandom_range(0, 15));
      3: return ~SampleBits'($urandom_range(0, 15));
      default: return SampleBits'($urandom_range(0, 65535));
    endcase
  endfunction

  // wait until all words and register writes are through and every result is back
  task automatic settle();
    while (accepted != issued || awaited_q.size() != 0 || cfg_done != cfg_posted)
      @(posedge clk_i);
  endtask

  // input word driver with random gaps
  int unsigned gap_left = 0;
  always @(posedge clk_i) begin : drive_words
    load_word_t w;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        advance_slot(func_i, sample_i);
        accepted++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (gap_left != 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (bursts_on && $urandom_range(0, 4) == 0) begin
          gap_left = $urandom_range(0, 6);
          in_valid_i <= 1'b0;
        end else if (word_q.size() != 0) begin
          w = word_q.pop_front();
          func_i     <= w.op;
          sample_i   <= w.sample;
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // register write driver; the predictor picks up a value when it is taken
  always @(posedge clk_i) begin : drive_regs
    reg_write_t rw;
    if (!rst_ni) begin
      cfg_valid_i <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == CFG_SLOTS_IN_USE) slots_cfg = cfg_data_i[SlotCntBits-1:0];
        else if (cfg_index_i == CFG_SMOOTHING_FACTOR) factor_cfg = cfg_data_i[FactorBits-1:0];
        cfg_done++;
      end
      if (!cfg_valid_i || cfg_ready_o) begin
        if (reg_q.size() != 0) begin
          rw = reg_q.pop_front();
          cfg_index_i <= rw.idx;
          cfg_data_i  <= rw.data;
          cfg_valid_i <= 1'b1;
        end else begin
          cfg_valid_i <= 1'b0;
        end
      end
    end
  end

  // result monitor with random stall bursts
  int unsigned hold_left = 0;
  always @(posedge clk_i) begin : watch_results
    slot_result_t want;
    slot_result_t got;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        got.prediction = prediction_o;
        got.slot       = slot_index_o;
        got.last       = cycle_end_o;
        if (awaited_q.size() == 0) begin
          note_fault($sformatf("unexpected word: prediction %0d slot %0d end %0b",
                               got.prediction, got.slot, got.last));
        end else begin
          want = awaited_q.pop_front();
          if (got.prediction !== want.prediction || got.slot !== want.slot ||
              got.last !== want.last)
            note_fault($sformatf({"mismatch: expected prediction %0d slot %0d end %0b, ",
                                  "got prediction %0d slot %0d end %0b"},
                                 want.prediction, want.slot, want.last,
                                 got.prediction, got.slot, got.last));
        end
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (bursts_on && $urandom_range(0, 5) == 0) begin
        hold_left = $urandom_range(0, 6);
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // stimulus: directed phases, then random phases of settings and words
  initial begin : stimulus
    int unsigned span;
    int unsigned sel;
    logic [SlotCntBits-1:0] slots_raw;
    logic [FactorBits-1:0]  factor_raw;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // four slots, written with stray upper bits; half weight
    post_reg(CFG_SLOTS_IN_USE, 17'h1FF84);
    post_reg(CFG_SMOOTHING_FACTOR, FactorHalf);
    settle();
    queue_word(FUNC_LOAD, 16'h0000);
    queue_word(FUNC_LOAD, 16'hFFFF);
    queue_word(FUNC_LOAD, 16'h5555);
    queue_word(FUNC_LOAD, 16'hAAAA);
    queue_word(FUNC_BLEND, 16'hFFFF);
    queue_word(FUNC_BLEND, 16'h0000);
    queue_word(FUNC_BLEND, 16'h0001);
    queue_word(FUNC_BLEND, 16'hFFFE);
    settle();

    // zero weight keeps the old value
    post_reg(CFG_SMOOTHING_FACTOR, '0);
    settle();
    queue_word(FUNC_BLEND, 16'hFFFF);
    queue_word(FUNC_BLEND, 16'h0000);
    queue_word(FUNC_BLEND, 16'h1234);
    settle();

    // full weight takes the sample
    post_reg(CFG_SMOOTHING_FACTOR, FactorOne);
    settle();
    queue_word(FUNC_BLEND, 16'h8001);
    queue_word(FUNC_BLEND, 16'h7FFE);
    settle();

    // weight above one is clipped to one
    post_reg(CFG_SMOOTHING_FACTOR, 17'h1FFFF);
    settle();
    queue_word(FUNC_BLEND, 16'hFFFF);
    queue_word(FUNC_BLEND, 16'h0000);
    settle();

    // slot count of zero acts as one; counter sits past the end
    post_reg(CFG_SLOTS_IN_USE, 17'h1FF80);
    settle();
    queue_word(FUNC_BLEND, 16'h4000);
    queue_word(FUNC_BLEND, 16'hC000);
    queue_word(FUNC_LOAD, 16'h0F0F);
    settle();

    // slot count too large acts as the maximum; smallest non-zero weight
    post_reg(CFG_SLOTS_IN_USE, 17'h0007F);
    post_reg(CFG_SMOOTHING_FACTOR, 17'd1);
    settle();
    queue_word(FUNC_BLEND, 16'hFFFF);
    queue_word(FUNC_BLEND, 16'hFFFF);
    queue_word(FUNC_BLEND, 16'h0000);
    queue_word(FUNC_BLEND, 16'h8000);
    settle();

    // lowered below the counter: current slot closes the cycle
    post_reg(CFG_SLOTS_IN_USE, 17'd2);
    settle();
    queue_word(FUNC_BLEND, 16'h2468);
    queue_word(FUNC_BLEND, 16'h1357);
    settle();

    // random phases
    while (issued < 1050) begin
      settle();
      bursts_on = (issued < 880) && ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 9))
        0:       slots_raw = '0;
        1:       slots_raw = SlotsMaxVal;
        2:       slots_raw = SlotCntBits'($urandom_range(65, 127));
        8, 9:    slots_raw = SlotCntBits'($urandom_range(1, 64));
        default: slots_raw = SlotCntBits'($urandom_range(1, 8));
      endcase
      case ($urandom_range(0, 7))
        0:       factor_raw = '0;
        1:       factor_raw = FactorOne;
        2:       factor_raw = FactorBits'($urandom_range(65537, 131071));
        3:       factor_raw = FactorBits'(1);
        4:       factor_raw = FactorBits'(65535);
        default: factor_raw = FactorBits'($urandom_range(0, 65536));
      endcase
      sel = $urandom_range(0, 2);
      if (sel != 1)
        post_reg(CFG_SLOTS_IN_USE,
                 {CfgDataBits'($urandom_range(0, 1023)) << SlotCntBits} | slots_raw);
      if (sel != 0)
        post_reg(CFG_SMOOTHING_FACTOR, factor_raw);
      settle();
      span = $urandom_range(20, 90);
      repeat (span)
        queue_word(($urandom_range(0, 99) < 85) ? FUNC_BLEND : FUNC_LOAD, pick_sample());
    end

    settle();
    repeat (8) @(posedge clk_i);
    if (faults == 0 && awaited_q.size() == 0) begin
      $display("PASS per_slot_ewma_load_predictor");
    end else begin
      $display("FAIL per_slot_ewma_load_predictor");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5_000_000;
    $display("FAIL per_slot_ewma_load_predictor");
    $finish;
  end

endmodule
